// ===== rtl/srgbxy_pkg.sv =====
package srgbxy_pkg;

  localparam int LIN_W  = 16;
  localparam int COEF_W = 20;
  localparam int PROD_W = LIN_W + COEF_W;
  localparam int SUM_W  = 38;
  localparam int OUT_W  = 16;

  localparam longint unsigned Q30        = 64'd1 << 30;
  localparam longint unsigned COEF_SCALE = 64'd1048576;
  localparam longint unsigned COEF_HALF  = 64'd500000;
  localparam longint unsigned COEF_DEN   = 64'd1000000;

  typedef logic [LIN_W-1:0]  lin_t;
  typedef logic [COEF_W-1:0] coef_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [SUM_W-1:0]  sum_t;

  localparam coef_t MATRIX_Q20 [3][3] = '{
    '{coef_t'((64'd664511 * COEF_SCALE + COEF_HALF) / COEF_DEN),
      coef_t'((64'd154324 * COEF_SCALE + COEF_HALF) / COEF_DEN),
      coef_t'((64'd162028 * COEF_SCALE + COEF_HALF) / COEF_DEN)},
    '{coef_t'((64'd283881 * COEF_SCALE + COEF_HALF) / COEF_DEN),
      coef_t'((64'd668433 * COEF_SCALE + COEF_HALF) / COEF_DEN),
      coef_t'((64'd47685  * COEF_SCALE + COEF_HALF) / COEF_DEN)},
    '{coef_t'((64'd88     * COEF_SCALE + COEF_HALF) / COEF_DEN),
      coef_t'((64'd72310  * COEF_SCALE + COEF_HALF) / COEF_DEN),
      coef_t'((64'd986039 * COEF_SCALE + COEF_HALF) / COEF_DEN)}
  };

  function automatic longint unsigned fifth_power_q30(input longint unsigned r);
    longint unsigned p2;
    longint unsigned p4;
    p2 = (r * r) >> 30;
    p4 = (p2 * p2) >> 30;
    return (p4 * r) >> 30;
  endfunction

  // The power branch finds t^0.4 by bisection on the fifth power, then
  // forms t^2 * t^0.4 and rounds it from Q30 to Q16.
  function automatic lin_t lin_entry(input logic use_lin,
                                     input longint unsigned lin_val,
                                     input longint unsigned t_val);
    longint unsigned t;
    longint unsigned s;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned o;
    int k;
    t  = (t_val > Q30) ? Q30 : t_val;
    s  = (t * t) >> 30;
    lo = 64'd0;
    hi = Q30;
    for (k = 0; k < 32; k++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        if (fifth_power_q30(mid) <= s) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    if (use_lin) begin
      o = lin_val;
    end else begin
      o = (((s * lo) >> 30) + (64'd1 << 13)) >> 14;
    end
    if (o > 64'd65535) begin
      o = 64'd65535;
    end
    return lin_t'(o);
  endfunction

endpackage

// ===== rtl/srgb_to_xy_chromaticity.sv =====
// One 8-bit sRGB pixel in, one CIE 1931 (x, y) chromaticity pair out, at a
// sustained rate of one pixel per clock while out_ready keeps the output
// moving. A pixel passes a transfer-curve table, the RGB-to-XYZ matrix, an
// adder tree, two restoring dividers that produce one quotient bit per stage
// and the output register. The pipeline stalls as a whole, and a two-beat
// output register pair lets one more pixel enter while a finished beat
// waits. A pixel whose X+Y+Z is zero gives x = y = 0 with black_input set.
module srgb_to_xy_chromaticity import srgbxy_pkg::*; #(
  parameter int COMPONENT_BITS  = 8,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [COMPONENT_BITS-1:0] red,
  input  logic [COMPONENT_BITS-1:0] green,
  input  logic [COMPONENT_BITS-1:0] blue,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [OUT_W-1:0]          chroma_x,
  output logic [OUT_W-1:0]          chroma_y,
  output logic                      black_input
);

  localparam int QW       = COORD_FRAC_BITS + 1;
  localparam int DivLat   = QW + 1;
  localparam int PipeLen  = 4 + DivLat;
  localparam logic [QW-1:0] Limit = (COORD_FRAC_BITS > 16) ? QW'(65535) :
                                    QW'((64'd1 << COORD_FRAC_BITS) - 64'd1);

  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic             black;
  } result_t;

  logic               en;
  logic [PipeLen-1:0] vld;
  logic [DivLat-1:0]  blk;
  logic [COMPONENT_BITS-1:0] comp [3];
  lin_t               lin  [3];
  prod_t              prod [3][3];
  sum_t               xyz  [3];
  sum_t               xnum;
  sum_t               ynum;
  sum_t               total;
  logic [QW-1:0]      qx;
  logic [QW-1:0]      qy;
  logic [QW-1:0]      qx_sat;
  logic [QW-1:0]      qy_sat;
  result_t            fin;
  result_t            skid;
  logic               skid_valid;

  assign en       = ~skid_valid;
  assign in_ready = en;

  assign comp[0] = red;
  assign comp[1] = green;
  assign comp[2] = blue;

  for (genvar c = 0; c < 3; c++) begin : g_lin
    srgbxy_lin_rom #(
      .COMPONENT_BITS(COMPONENT_BITS)
    ) u_lin_rom (
      .clk (clk),
      .en  (en),
      .code(comp[c]),
      .lin (lin[c])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= PROD_W'(lin[j]) * PROD_W'(MATRIX_Q20[i][j]);
        end
      end
      for (int i = 0; i < 3; i++) begin
        xyz[i] <= SUM_W'(prod[i][0]) + SUM_W'(prod[i][1]) + SUM_W'(prod[i][2]);
      end
      xnum  <= xyz[0];
      ynum  <= xyz[1];
      total <= xyz[0] + xyz[1] + xyz[2];
      blk   <= {blk[DivLat-2:0], total == '0};
    end
  end

  srgbxy_div #(
    .FRAC_BITS(COORD_FRAC_BITS)
  ) u_div_x (
    .clk(clk),
    .en (en),
    .num(xnum),
    .sum(total),
    .quo(qx)
  );

  srgbxy_div #(
    .FRAC_BITS(COORD_FRAC_BITS)
  ) u_div_y (
    .clk(clk),
    .en (en),
    .num(ynum),
    .sum(total),
    .quo(qy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PipeLen-2:0], in_valid};
    end
  end

  assign qx_sat = (qx > Limit) ? Limit : qx;
  assign qy_sat = (qy > Limit) ? Limit : qy;

  always_comb begin
    fin.black = blk[DivLat-1];
    fin.x     = fin.black ? '0 : OUT_W'(qx_sat);
    fin.y     = fin.black ? '0 : OUT_W'(qy_sat);
  end

  // A beat leaving the pipeline goes to the output register when it is free
  // and to the skid register otherwise; a full skid register stalls the pipe.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        chroma_x    <= skid.x;
        chroma_y    <= skid.y;
        black_input <= skid.black;
        skid_valid  <= 1'b0;
      end
    end else if (vld[PipeLen-1]) begin
      if (~out_valid | out_ready) begin
        out_valid   <= 1'b1;
        chroma_x    <= fin.x;
        chroma_y    <= fin.y;
        black_input <= fin.black;
      end else begin
        skid_valid <= 1'b1;
        skid       <= fin;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/srgbxy_lin_rom.sv =====
module srgbxy_lin_rom import srgbxy_pkg::*; #(
  parameter int COMPONENT_BITS = 8
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [COMPONENT_BITS-1:0] code,
  output lin_t                      lin
);

  localparam int Depth = 1 << COMPONENT_BITS;
  localparam longint unsigned CompMax = 64'(Depth - 1);

  lin_t rom_data [Depth];

  for (genvar i = 0; i < Depth; i++) begin : g_entry
    localparam longint unsigned Cv = 64'(i);
    localparam logic UseLin = (Cv * 64'd100000) <= (64'd4045 * CompMax);
    localparam longint unsigned LinVal =
      (Cv * 64'd6553600 + 64'd646 * CompMax) / (64'd1292 * CompMax);
    localparam longint unsigned TVal =
      ((Cv * 64'd1000 + 64'd55 * CompMax) << 30) / (64'd1055 * CompMax);
    localparam lin_t Entry = lin_entry(UseLin, LinVal, TVal);
    assign rom_data[i] = Entry;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lin <= rom_data[code];
    end
  end

endmodule

// ===== rtl/srgbxy_div.sv =====
module srgbxy_div import srgbxy_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             en,
  input  sum_t             num,
  input  sum_t             sum,
  output logic [FRAC_BITS:0] quo
);

  localparam int QW = FRAC_BITS + 1;
  localparam int NW = SUM_W + QW;

  // The rounded quotient (num * 2^F + sum / 2) / sum is built one bit per
  // stage by restoring division. The dividend is below sum * 2^QW, so its
  // upper part starts below the divisor and only QW bits remain to shift in.
  logic [NW-1:0] dividend;
  sum_t          rem  [QW+1];
  logic [QW-1:0] low  [QW+1];
  logic [QW-1:0] qacc [QW+1];
  sum_t          dsum [QW+1];

  assign dividend = NW'({num, {FRAC_BITS{1'b0}}}) + NW'(sum >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= dividend[NW-1:QW];
      low[0]  <= dividend[QW-1:0];
      qacc[0] <= '0;
      dsum[0] <= sum;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [SUM_W:0] trial;
    logic [SUM_W:0] diff;
    logic           ge;

    assign trial = {rem[k], low[k][QW-1]};
    assign ge    = trial >= {1'b0, dsum[k]};
    assign diff  = trial - {1'b0, dsum[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
        low[k+1]  <= low[k] << 1;
        qacc[k+1] <= {qacc[k][QW-2:0], ge};
        dsum[k+1] <= dsum[k];
      end
    end
  end

  assign quo = qacc[QW];

endmodule

// ===== bench/srgb_to_xy_chromaticity_test.sv =====
`timescale 1ns / 1ps

module srgb_to_xy_chromaticity_test;
  import srgbxy_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic             black;
  } chroma_t;

  localparam longint unsigned FULL_SCALE = 255;
  localparam int              FRAC_BITS  = 16;
  localparam int              TAIL_ITEMS = 60;
  localparam int              HOLD_CYCLES = 200;

  localparam longint unsigned XYZ_MILLIONTHS [9] = '{
    664511, 154324, 162028,
    283881, 668433, 47685,
    88,     72310,  986039
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       red = 8'd0;
  logic [7:0]       green = 8'd0;
  logic [7:0]       blue = 8'd0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [OUT_W-1:0] chroma_x;
  logic [OUT_W-1:0] chroma_y;
  logic             black_input;

  pixel_t          pixel_queue [$];
  chroma_t         pending_chroma [$];
  pixel_t          offered_pixel;
  longint unsigned curve_q16 [256];
  longint unsigned xyz_q20 [9];
  int              mismatch_count = 0;
  int              accepted_count = 0;
  int              total_items = 0;
  int              send_gap = 0;
  int              recv_gap = 0;
  logic            long_hold = 1'b0;

  srgb_to_xy_chromaticity dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .chroma_x   (chroma_x),
    .chroma_y   (chroma_y),
    .black_input(black_input)
  );

  always #6 clk = ~clk;

  function automatic longint unsigned fifth_q30(input longint unsigned r);
    longint unsigned sq;
    longint unsigned quad;
    sq   = (r * r) >> 30;
    quad = (sq * sq) >> 30;
    return (quad * r) >> 30;
  endfunction

  function automatic longint unsigned decode_gamma(input longint unsigned code);
    longint unsigned t;
    longint unsigned s;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned v;
    if (code * 100000 <= 4045 * FULL_SCALE) begin
      v = (code * 6553600 + 646 * FULL_SCALE) / (1292 * FULL_SCALE);
    end else begin
      t = ((code * 1000 + 55 * FULL_SCALE) << 30) / (1055 * FULL_SCALE);
      if (t > (64'd1 << 30)) begin
        t = 64'd1 << 30;
      end
      s  = (t * t) >> 30;
      lo = 0;
      hi = 64'd1 << 30;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        if (fifth_q30(mid) <= s) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
      v = (((s * lo) >> 30) + (64'd1 << 13)) >> 14;
    end
    if (v > 65535) begin
      v = 65535;
    end
    return v;
  endfunction

  function automatic longint unsigned to_coord(input longint unsigned num,
                                               input longint unsigned total);
    longint unsigned q;
    q = ((num << FRAC_BITS) + total / 2) / total;
    return (q > 65535) ? 65535 : q;
  endfunction

  function automatic chroma_t predict_chromaticity(input pixel_t px);
    longint unsigned lin [3];
    longint unsigned xyz [3];
    longint unsigned total;
    chroma_t         c;
    lin[0] = curve_q16[px.red];
    lin[1] = curve_q16[px.green];
    lin[2] = curve_q16[px.blue];
    for (int i = 0; i < 3; i++) begin
      xyz[i] = 0;
      for (int j = 0; j < 3; j++) begin
        xyz[i] += lin[j] * xyz_q20[3 * i + j];
      end
    end
    total = xyz[0] + xyz[1] + xyz[2];
    if (total == 0) begin
      c.x     = '0;
      c.y     = '0;
      c.black = 1'b1;
    end else begin
      c.x     = OUT_W'(to_coord(xyz[0], total));
      c.y     = OUT_W'(to_coord(xyz[1], total));
      c.black = 1'b0;
    end
    return c;
  endfunction

  task automatic note_mismatch(input string msg);
    if (mismatch_count < 100) begin
      $display("mismatch at %0t ns: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  task automatic add_pixel(input int r, input int g, input int b);
    pixel_t px;
    px.red   = 8'(r);
    px.green = 8'(g);
    px.blue  = 8'(b);
    pixel_queue.insert(pixel_queue.size(), px);
    total_items++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_chroma.insert(pending_chroma.size(),
                              predict_chromaticity(offered_pixel));
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pixel_queue.size() > 0) begin
          offered_pixel = pixel_queue.pop_front();
          in_valid <= 1'b1;
          red      <= offered_pixel.red;
          green    <= offered_pixel.green;
          blue     <= offered_pixel.blue;
          if (pixel_queue.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 15);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    chroma_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_chroma.size() == 0) begin
          note_mismatch("output beat with no pixel outstanding");
        end else begin
          want = pending_chroma.pop_front();
          if (chroma_x !== want.x) begin
            note_mismatch($sformatf("chroma_x got %0d want %0d", chroma_x, want.x));
          end
          if (chroma_y !== want.y) begin
            note_mismatch($sformatf("chroma_y got %0d want %0d", chroma_y, want.y));
          end
          if (black_input !== want.black) begin
            note_mismatch($sformatf("black_input got %b want %b", black_input,
                                    want.black));
          end
        end
      end
      if (long_hold) begin
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (pixel_queue.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
          recv_gap = $urandom_range(1, 15);
        end
      end
    end
  end

  // The receiver stalls for a long stretch so the pipeline fills and in_ready drops.
  initial begin
    wait (accepted_count >= 120);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    #5000000;
    $display("srgb_to_xy_chromaticity regression: fail");
    $finish;
  end

  initial begin
    int kind;
    int v;
    for (int k = 0; k < 9; k++) begin
      xyz_q20[k] = (XYZ_MILLIONTHS[k] * 1048576 + 500000) / 1000000;
    end
    for (int c = 0; c < 256; c++) begin
      curve_q16[c] = decode_gamma(c);
    end

    add_pixel(0, 0, 0);
    add_pixel(255, 255, 255);
    add_pixel(255, 0, 0);
    add_pixel(0, 255, 0);
    add_pixel(0, 0, 255);
    add_pixel(1, 0, 0);
    add_pixel(0, 1, 0);
    add_pixel(0, 0, 1);
    add_pixel(10, 10, 10);
    add_pixel(11, 11, 11);
    add_pixel(10, 11, 12);
    add_pixel(255, 255, 0);
    add_pixel(0, 255, 255);
    add_pixel(255, 0, 255);
    add_pixel(128, 128, 128);
    add_pixel(170, 85, 42);
    add_pixel(1, 1, 1);
    add_pixel(254, 0, 0);
    add_pixel(0, 0, 0);
    add_pixel(255, 1, 0);

    for (int n = 0; n < 500; n++) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        add_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      end else if (kind < 7) begin
        add_pixel($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15));
      end else if (kind == 7) begin
        v = $urandom_range(0, 255);
        add_pixel(v, v, v);
      end else if (kind == 8) begin
        add_pixel($urandom_range(0, 1) * $urandom_range(0, 255),
                  $urandom_range(0, 1) * $urandom_range(0, 255),
                  $urandom_range(0, 1) * $urandom_range(0, 255));
      end else begin
        add_pixel($urandom_range(240, 255), $urandom_range(0, 255), $urandom_range(240, 255));
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    wait (accepted_count == total_items);
    wait (pending_chroma.size() == 0);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_chroma.size() == 0) begin
      $display("srgb_to_xy_chromaticity regression: pass");
    end else begin
      $display("srgb_to_xy_chromaticity regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/srgbxy_pkg.sv
rtl/srgbxy_lin_rom.sv
rtl/srgbxy_div.sv
rtl/srgb_to_xy_chromaticity.sv
bench/srgb_to_xy_chromaticity_test.sv
